/* rtl/bfbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared types and constants of the best-fit bin packer.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned BIN_INDEX_W = 6;
  localparam logic [SIZE_W-1:0] CAP_RESET = 16'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

endpackage

/* rtl/bfbp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfbp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/best_fit_bin_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_bin_packer
// Online best-fit bin packer over a bounded table of bin capacities.
// ----------------------------------------------------------------------------
// An object size is taken on the input channel, the open bins are scanned one
// per cycle through the single read port of the bin table, and the bin whose
// remaining capacity is the smallest that still fits (lowest index on ties)
// receives the object; failing that a new bin is opened at bin_capacity, or
// the status reports an oversized object or a full table. The block holds one
// object at a time, through its scan of the table. The result sits in an
// output register, so the next object may be taken while it waits for its
// transfer; the decision on that next object then waits until the output
// register is free. The table needs no clearing after reset; the open-bin
// count covers it. bin_capacity is written through the config channel; the user
// must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module best_fit_bin_packer #(
  parameter int unsigned MAX_BINS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_bin_capacity_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] object_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  bin_index_o,
  output logic        opened_new_o,
  output logic [1:0]  status_o
);

  localparam int unsigned IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam int unsigned SW = bfbp_pkg::SIZE_W;
  localparam int unsigned OW = bfbp_pkg::BIN_INDEX_W;

  bfbp_pkg::state_e state_q, state_d;

  logic [SW-1:0] cap_q;
  logic [CW-1:0] open_q, open_d;
  logic [SW-1:0] size_q, size_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          found_q, found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [SW-1:0] best_rem_q, best_rem_d;

  logic          out_vld_q, out_vld_d;
  logic [IW-1:0] out_idx_q, out_idx_d;
  logic          out_new_q, out_new_d;
  bfbp_pkg::status_e out_st_q, out_st_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata;

  logic          fits, better, slot_free;
  logic [IW+OW-1:0] idx_ext;

  bfbp_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign fits      = ram_rdata >= size_q;
  assign better    = !found_q || (ram_rdata < best_rem_q);
  assign slot_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    open_d     = open_q;
    size_d     = size_q;
    iss_d      = iss_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_rem_d = best_rem_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_idx_d  = out_idx_q;
    out_new_d  = out_new_q;
    out_st_d   = out_st_q;
    ram_we     = 1'b0;
    ram_waddr  = best_idx_q;
    ram_wdata  = best_rem_q - size_q;
    ram_re     = 1'b0;
    ram_raddr  = iss_q[IW-1:0];
    in_ready_o = 1'b0;

    unique case (state_q)
      bfbp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          size_d  = object_size_i;
          iss_d   = '0;
          found_d = 1'b0;
          state_d = (open_q == '0) ? bfbp_pkg::ST_DECIDE : bfbp_pkg::ST_SCAN;
        end
      end
      bfbp_pkg::ST_SCAN: begin
        if (iss_q != open_q) begin
          ram_re    = 1'b1;
          iss_d     = iss_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = iss_q[IW-1:0];
        end else begin
          state_d = bfbp_pkg::ST_DECIDE;
        end
        if (cmp_vld_q && fits && better) begin
          found_d    = 1'b1;
          best_idx_d = cmp_idx_q;
          best_rem_d = ram_rdata;
        end
      end
      bfbp_pkg::ST_DECIDE: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          out_idx_d = '0;
          out_new_d = 1'b0;
          out_st_d  = bfbp_pkg::STATUS_OK;
          state_d   = bfbp_pkg::ST_IDLE;
          if (found_q) begin
            ram_we    = 1'b1;
            out_idx_d = best_idx_q;
          end else if (size_q > cap_q) begin
            out_st_d = bfbp_pkg::STATUS_TOO_LARGE;
          end else if (open_q == CW'(MAX_BINS)) begin
            out_st_d = bfbp_pkg::STATUS_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = open_q[IW-1:0];
            ram_wdata = cap_q - size_q;
            open_d    = open_q + 1'b1;
            out_idx_d = open_q[IW-1:0];
            out_new_d = 1'b1;
          end
        end
      end
      default: state_d = bfbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bfbp_pkg::ST_IDLE;
      cap_q     <= bfbp_pkg::CAP_RESET;
      open_q    <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_bin_capacity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    iss_q      <= iss_d;
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_rem_q <= best_rem_d;
    out_idx_q  <= out_idx_d;
    out_new_q  <= out_new_d;
    out_st_q   <= out_st_d;
  end

  assign idx_ext      = {{OW{1'b0}}, out_idx_q};
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_vld_q;
  assign bin_index_o  = idx_ext[OW-1:0];
  assign opened_new_o = out_new_q;
  assign status_o     = out_st_q;

endmodule

/* rtl/bfbp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbp_checker
// Port-level checks on the best-fit bin packer, bound to the top level.
// ----------------------------------------------------------------------------
module bfbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  bin_index_o,
  input logic        opened_new_o,
  input logic [1:0]  status_o
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_index_o)
      && $stable(opened_new_o) && $stable(status_o))
    else $error("result changed while stalled");

  // failed placement reports no bin
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bfbp_pkg::STATUS_OK) |->
      (bin_index_o == 6'd0) && !opened_new_o)
    else $error("failed placement carries a bin");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == bfbp_pkg::STATUS_OK)
      || (status_o == bfbp_pkg::STATUS_TOO_LARGE)
      || (status_o == bfbp_pkg::STATUS_FULL))
    else $error("undefined status code");

  // one object at a time
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

endmodule

bind best_fit_bin_packer bfbp_checker u_bfbp_checker (.*);

/* tb/sv/best_fit_bin_packer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_bin_packer_tb
// Self-checking testbench for the best-fit bin packer.
// ----------------------------------------------------------------------------
// A short directed table covers field extremes, exact fits, zero-size objects,
// oversized objects and capacity changes with bins open. Three random phases
// follow, each with its own capacity and size mix and its own idle pattern on
// the input and result channels. The later phases fill the bin table, so the
// full-table and oversized-on-full cases are reached. Each transfer is checked
// against its row's expected result or an in-bench best-fit packer's own table.
// ----------------------------------------------------------------------------
module best_fit_bin_packer_tb;

  localparam int unsigned SIZE_W      = bfbp_pkg::SIZE_W;
  localparam int unsigned BIN_INDEX_W = bfbp_pkg::BIN_INDEX_W;
  localparam int unsigned TB_MAX_BINS = 64;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 330;
  localparam int unsigned PLAN_ROWS   = 19;

  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin;
    logic                   opened;
    bfbp_pkg::status_e      status;
  } placement_t;

  typedef enum logic { ROW_OBJECT, ROW_CAPACITY } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [SIZE_W-1:0] value;
    logic              typed;
    placement_t        want;
  } plan_row_t;

  logic                   clk_i              = 1'b0;
  logic                   rst_ni             = 1'b0;
  logic                   cfg_valid_i        = 1'b0;
  logic                   cfg_ready_o;
  logic [15:0]            cfg_bin_capacity_i = '0;
  logic                   in_valid_i         = 1'b0;
  logic                   in_ready_o;
  logic [15:0]            object_size_i      = '0;
  logic                   out_valid_o;
  logic                   out_ready_i        = 1'b0;
  logic [5:0]             bin_index_o;
  logic                   opened_new_o;
  logic [1:0]             status_o;

  logic [SIZE_W-1:0]      bin_left [TB_MAX_BINS];
  int unsigned            bins_used    = 0;
  logic [SIZE_W-1:0]      capacity_now = bfbp_pkg::CAP_RESET;
  placement_t             placements [$];
  int unsigned            mismatches   = 0;
  int unsigned            quiet_cycles = 0;
  int unsigned            tx_idle_pct  = 7;
  int unsigned            rx_idle_pct  = 45;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_OBJECT,   16'd0,     1'b1, '{6'd0, 1'b1, bfbp_pkg::STATUS_OK}},
    '{ROW_OBJECT,   16'd100,   1'b1, '{6'd0, 1'b0, bfbp_pkg::STATUS_OK}},
    '{ROW_OBJECT,   16'd101,   1'b1, '{6'd0, 1'b0, bfbp_pkg::STATUS_TOO_LARGE}},
    '{ROW_OBJECT,   16'd65535, 1'b1, '{6'd0, 1'b0, bfbp_pkg::STATUS_TOO_LARGE}},
    '{ROW_OBJECT,   16'd0,     1'b1, '{6'd0, 1'b0, bfbp_pkg::STATUS_OK}},
    '{ROW_OBJECT,   16'd60,    1'b1, '{6'd1, 1'b1, bfbp_pkg::STATUS_OK}},
    '{ROW_OBJECT,   16'd50,    1'b1, '{6'd2, 1'b1, bfbp_pkg::STATUS_OK}},
    '{ROW_OBJECT,   16'd40,    1'b1, '{6'd1, 1'b0, bfbp_pkg::STATUS_OK}},
    '{ROW_OBJECT,   16'd30,    1'b0, '0},
    '{ROW_CAPACITY, 16'd65535, 1'b0, '0},
    '{ROW_OBJECT,   16'd65535, 1'b1, '{6'd3, 1'b1, bfbp_pkg::STATUS_OK}},
    '{ROW_OBJECT,   16'd21,    1'b0, '0},
    '{ROW_OBJECT,   16'd20,    1'b0, '0},
    '{ROW_CAPACITY, 16'd0,     1'b0, '0},
    '{ROW_OBJECT,   16'd1,     1'b0, '0},
    '{ROW_OBJECT,   16'd65535, 1'b1, '{6'd0, 1'b0, bfbp_pkg::STATUS_TOO_LARGE}},
    '{ROW_OBJECT,   16'd0,     1'b1, '{6'd0, 1'b0, bfbp_pkg::STATUS_OK}},
    '{ROW_CAPACITY, 16'd1,     1'b0, '0},
    '{ROW_OBJECT,   16'd1,     1'b0, '0}
  };

  best_fit_bin_packer #(
    .MAX_BINS(TB_MAX_BINS)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_bin_capacity_i (cfg_bin_capacity_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .object_size_i      (object_size_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .bin_index_o        (bin_index_o),
    .opened_new_o       (opened_new_o),
    .status_o           (status_o)
  );

  always #5 clk_i = ~clk_i;

  // best fit over the open bins, lowest index on ties, else open a new bin or report too large or full
  function automatic placement_t place_object(input logic [SIZE_W-1:0] size);
    placement_t  res;
    int unsigned best;
    bit          found;
    res   = '{bin: '0, opened: 1'b0, status: bfbp_pkg::STATUS_OK};
    best  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < bins_used; i++) begin
      if (bin_left[i] >= size && (!found || bin_left[i] < bin_left[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      bin_left[best] = bin_left[best] - size;
      res.bin        = best[BIN_INDEX_W-1:0];
    end else if (size > capacity_now) begin
      res.status = bfbp_pkg::STATUS_TOO_LARGE;
    end else if (bins_used >= TB_MAX_BINS) begin
      res.status = bfbp_pkg::STATUS_FULL;
    end else begin
      bin_left[bins_used] = capacity_now - size;
      res.bin             = bins_used[BIN_INDEX_W-1:0];
      res.opened          = 1'b1;
      bins_used++;
    end
    return res;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] cap,
                                                  input int unsigned divisor);
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(99);
    top  = (int'(cap) / divisor > 0) ? int'(cap) / divisor : 1;
    if (roll < 5) return '0;
    if (roll < 9) return SIZE_W'($urandom);
    if (roll < 13 && cap != 16'hffff) return SIZE_W'($urandom_range(65535, int'(cap) + 1));
    return SIZE_W'($urandom_range(top, 1));
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_object(input logic [SIZE_W-1:0] size, input logic typed,
                             input placement_t want);
    placement_t got;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    object_size_i <= size;
    do @(posedge clk_i); while (!in_ready_o);
    got = place_object(size);
    placements.push_back(typed ? want : got);
  endtask

  // lets every outstanding result drain and the scan settle before a register write
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (placements.size() != 0) @(posedge clk_i);
    repeat (TB_MAX_BINS + 8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_bin_capacity_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_now = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin : check_result
    placement_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (placements.size() == 0) begin
        flag_mismatch($sformatf("unexpected result bin %0d opened %0d status %0d",
                                bin_index_o, opened_new_o, status_o));
      end else begin
        want = placements.pop_front();
        if (bin_index_o !== want.bin)
          flag_mismatch($sformatf("bin_index %0d, expected %0d", bin_index_o, want.bin));
        if (opened_new_o !== want.opened)
          flag_mismatch($sformatf("opened_new %0d, expected %0d", opened_new_o, want.opened));
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %s", status_o, want.status.name()));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("best_fit_bin_packer_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [SIZE_W-1:0] phase_cap [3];
    int unsigned       phase_div [3];
    int unsigned       phase_tx  [3];
    int unsigned       phase_rx  [3];
    phase_cap = '{SIZE_W'($urandom_range(5000, 1000)), 16'hffff,
                  SIZE_W'($urandom_range(255, 1))};
    phase_div = '{8, 2, 1};
    phase_tx  = '{7, 45, 0};
    phase_rx  = '{45, 7, 0};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CAPACITY) begin
        drain();
        write_capacity(plan[r].value);
      end else begin
        send_object(plan[r].value, plan[r].typed, plan[r].want);
      end
    end

    for (int p = 0; p < 3; p++) begin
      drain();
      tx_idle_pct = phase_tx[p];
      rx_idle_pct = phase_rx[p];
      write_capacity(phase_cap[p]);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++)
        send_object(pick_size(phase_cap[p], phase_div[p]), 1'b0, '0);
    end

    drain();
    if (placements.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", placements.size()));
    if (mismatches == 0) begin
      $display("best_fit_bin_packer_tb passed");
    end else begin
      $display("best_fit_bin_packer_tb failed");
    end
    $finish;
  end

endmodule

/* best_fit_bin_packer.f */
rtl/bfbp_pkg.sv
rtl/bfbp_ram.sv
rtl/best_fit_bin_packer.sv
rtl/bfbp_checker.sv
tb/sv/best_fit_bin_packer_tb.sv
